>>> design/sexpr_tok_pkg.sv
package sexpr_tok_pkg;

	// byte codes the lexer reacts to
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// token kinds
	localparam logic [1:0] KIND_OPEN   = 2'd0;
	localparam logic [1:0] KIND_CLOSE  = 2'd1;
	localparam logic [1:0] KIND_STRING = 2'd2;
	localparam logic [1:0] KIND_SYMBOL = 2'd3;

	// result queue depth
	localparam int QDEPTH = 3;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// lexer mode, one-hot
	typedef enum logic [4:0] {
		M_IDLE    = 5'b00001,
		M_SEMI    = 5'b00010,
		M_COMMENT = 5'b00100,
		M_SYMBOL  = 5'b01000,
		M_STRING  = 5'b10000
	} lex_mode_t;

	// one result word
	typedef struct packed {
		logic [7:0] chr;
		logic [1:0] kind;
		logic       first;
		logic       last;
		logic       unterm;
		logic       run_last;
	} tok_res_t;

	// lexer to queue push group
	typedef struct packed {
		logic [1:0] n;
		tok_res_t   r0;
		tok_res_t   r1;
	} tok_push_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

endpackage

>>> design/sexpr_tokenizer_top.sv
// channel | valid     | stall     | payload
// source  | src_valid | src_stall | ch
// token   | tok_valid | tok_stall | out_char, token_kind, token_first,
//         |           |           | token_last, unterminated, run_last
//
// A text byte is registered on acceptance, runs through the lexer step once
// the queue has room and lands in a three-word result queue; one byte per
// cycle unless stalled. A byte yields zero, one or two words; output drains
// one word per cycle while tok_stall is low, so two-word bytes can stall the
// source. The source stalls only when the queue cannot take two more words.
// Reset puts the lexer between tokens with nothing held and the queue empty.
module sexpr_tokenizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] ch,
	output logic       tok_valid,
	input  logic       tok_stall,
	output logic [7:0] out_char,
	output logic [1:0] token_kind,
	output logic       token_first,
	output logic       token_last,
	output logic       unterminated,
	output logic       run_last
);
	import sexpr_tok_pkg::*;

	logic [7:0]     ch_s1;
	logic           vld_s1;
	logic           go;
	logic           pop;
	logic [QCW-1:0] count;
	tok_push_t      push;
	tok_res_t       head;
	lex_mode_t      mode;

	// room for two words, counting this cycle's pop
	assign pop       = tok_valid && !tok_stall;
	assign go        = vld_s1 && ((count <= QCW'(QDEPTH - 2)) ||
		(count == QCW'(QDEPTH - 1) && pop));
	assign src_stall = vld_s1 && !go;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (!src_stall)
			vld_s1 <= src_valid;
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			ch_s1 <= ch;
	end

	sexpr_tok_lex u_lex (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.ch_s1  (ch_s1),
		.push   (push),
		.mode   (mode)
	);

	sexpr_tok_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.count  (count),
		.head   (head)
	);

	assign tok_valid    = count != '0;
	assign out_char     = head.chr;
	assign token_kind   = head.kind;
	assign token_first  = head.first;
	assign token_last   = head.last;
	assign unterminated = head.unterm;
	assign run_last     = head.run_last;

	// queue never overfills
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= QCW'(QDEPTH))
		else $error("result queue overflow");

	// end of text always returns the lexer to idle
	a_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ch_s1 == CH_NUL) |=> (mode == M_IDLE))
		else $error("lexer not idle after end of text");

	// parenthesis tokens are single bytes
	a_paren_single: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (token_kind == KIND_OPEN || token_kind == KIND_CLOSE))
		|-> (token_first && token_last))
		else $error("paren token not a single byte");

	// an unterminated flag only sits on the last byte of a string
	a_unterm: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && unterminated) |-> (token_last && token_kind == KIND_STRING && run_last))
		else $error("bad unterminated flag");

endmodule

>>> design/sexpr_tok_lex.sv
module sexpr_tok_lex (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [7:0]              ch_s1,
	output sexpr_tok_pkg::tok_push_t push,
	output sexpr_tok_pkg::lex_mode_t mode
);
	import sexpr_tok_pkg::*;

	lex_mode_t  mode_q, mode_d;
	logic       esc_q, esc_d;
	logic       hv_q, hv_d;
	logic [7:0] hc_q, hc_d;
	logic [1:0] hk_q, hk_d;
	logic       hf_q, hf_d;

	tok_res_t   emit [2];
	logic [1:0] cnt;
	logic       sym_step;
	logic       paren;
	logic [1:0] pkind;

	assign paren = (ch_s1 == CH_LPAREN) || (ch_s1 == CH_RPAREN);
	assign pkind = (ch_s1 == CH_LPAREN) ? KIND_OPEN : KIND_CLOSE;

	// one lexer step on the staged byte
	always_comb begin
		emit[0]  = '0;
		emit[1]  = '0;
		cnt      = 2'd0;
		sym_step = 1'b0;
		mode_d   = mode_q;
		esc_d    = esc_q;
		hv_d     = hv_q;
		hc_d     = hc_q;
		hk_d     = hk_q;
		hf_d     = hf_q;
		if (ch_s1 == CH_NUL) begin
			// end of text: flush held byte, then back to reset state
			if (hv_q) begin
				emit[cnt[0]] = '{hc_q, hk_q, hf_q, 1'b1, mode_q == M_STRING, 1'b0};
				cnt = cnt + 2'd1;
			end
			hv_d   = 1'b0;
			esc_d  = 1'b0;
			mode_d = M_IDLE;
		end else begin
			case (mode_q)
				M_COMMENT: begin
					if (ch_s1 == CH_LF || ch_s1 == CH_CR)
						mode_d = M_IDLE;
				end
				M_SEMI: begin
					if (ch_s1 == CH_SEMI) begin
						hv_d   = 1'b0;
						mode_d = M_COMMENT;
					end else begin
						sym_step = 1'b1;
					end
				end
				M_SYMBOL: begin
					sym_step = 1'b1;
				end
				M_STRING: begin
					if (hv_q) begin
						emit[cnt[0]] = '{hc_q, hk_q, hf_q, 1'b0, 1'b0, 1'b0};
						cnt = cnt + 2'd1;
					end
					hv_d = 1'b0;
					if (esc_q) begin
						esc_d = 1'b0;
						hv_d  = 1'b1; hc_d = ch_s1; hk_d = KIND_STRING; hf_d = 1'b0;
					end else if (ch_s1 == CH_BSLASH) begin
						esc_d = 1'b1;
						hv_d  = 1'b1; hc_d = ch_s1; hk_d = KIND_STRING; hf_d = 1'b0;
					end else if (ch_s1 == CH_QUOTE) begin
						emit[cnt[0]] = '{ch_s1, KIND_STRING, 1'b0, 1'b1, 1'b0, 1'b0};
						cnt = cnt + 2'd1;
						mode_d = M_IDLE;
					end else begin
						hv_d = 1'b1; hc_d = ch_s1; hk_d = KIND_STRING; hf_d = 1'b0;
					end
				end
				default: begin
					// idle, and any stray code
					if (hv_q) begin
						emit[cnt[0]] = '{hc_q, hk_q, hf_q, 1'b1, 1'b0, 1'b0};
						cnt = cnt + 2'd1;
					end
					hv_d   = 1'b0;
					esc_d  = 1'b0;
					mode_d = M_IDLE;
					if (is_blank(ch_s1)) begin
						hv_d = 1'b0;
					end else if (paren) begin
						emit[cnt[0]] = '{ch_s1, pkind, 1'b1, 1'b1, 1'b0, 1'b0};
						cnt = cnt + 2'd1;
					end else if (ch_s1 == CH_QUOTE) begin
						hv_d = 1'b1; hc_d = ch_s1; hk_d = KIND_STRING; hf_d = 1'b1;
						mode_d = M_STRING;
					end else if (ch_s1 == CH_SEMI) begin
						hv_d = 1'b1; hc_d = ch_s1; hk_d = KIND_SYMBOL; hf_d = 1'b1;
						mode_d = M_SEMI;
					end else begin
						hv_d = 1'b1; hc_d = ch_s1; hk_d = KIND_SYMBOL; hf_d = 1'b1;
						mode_d = M_SYMBOL;
					end
				end
			endcase

			// symbol body, also a lone ';' that turned out to start a symbol
			if (sym_step) begin
				if (is_blank(ch_s1)) begin
					if (hv_q) begin
						emit[cnt[0]] = '{hc_q, hk_q, hf_q, 1'b1, 1'b0, 1'b0};
						cnt = cnt + 2'd1;
					end
					hv_d   = 1'b0;
					mode_d = M_IDLE;
				end else if (paren) begin
					if (hv_q) begin
						emit[cnt[0]] = '{hc_q, hk_q, hf_q, 1'b1, 1'b0, 1'b0};
						cnt = cnt + 2'd1;
					end
					emit[cnt[0]] = '{ch_s1, pkind, 1'b1, 1'b1, 1'b0, 1'b0};
					cnt = cnt + 2'd1;
					hv_d   = 1'b0;
					mode_d = M_IDLE;
				end else begin
					if (hv_q) begin
						emit[cnt[0]] = '{hc_q, hk_q, hf_q, 1'b0, 1'b0, 1'b0};
						cnt = cnt + 2'd1;
					end
					hv_d = 1'b1; hc_d = ch_s1; hk_d = KIND_SYMBOL; hf_d = 1'b0;
					mode_d = M_SYMBOL;
				end
			end
		end

		// mark the last word this byte produced
		if (cnt == 2'd1)
			emit[0].run_last = 1'b1;
		else if (cnt == 2'd2)
			emit[1].run_last = 1'b1;
	end

	assign push.n  = go ? cnt : 2'd0;
	assign push.r0 = emit[0];
	assign push.r1 = emit[1];
	assign mode    = mode_q;

	// lexer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			esc_q  <= 1'b0;
			hv_q   <= 1'b0;
		end else if (go) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			hv_q   <= hv_d;
		end
	end

	// held byte payload
	always_ff @(posedge clk) begin
		if (go) begin
			hc_q <= hc_d;
			hk_q <= hk_d;
			hf_q <= hf_d;
		end
	end

endmodule

>>> design/sexpr_tok_outq.sv
module sexpr_tok_outq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sexpr_tok_pkg::tok_push_t            push,
	input  logic                                pop,
	output logic [sexpr_tok_pkg::QCW-1:0]       count,
	output sexpr_tok_pkg::tok_res_t             head
);
	import sexpr_tok_pkg::*;

	tok_res_t         mem_q [QDEPTH];
	logic [QPW-1:0]   rd_q, wr_q, wr1;
	logic [QCW-1:0]   cnt_q;
	logic [QCW:0]     cnt_n;

	function automatic logic [QPW-1:0] inc(input logic [QPW-1:0] p);
		return (p == QPW'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr1   = inc(wr_q);
	assign cnt_n = (QCW+1)'(cnt_q) + (QCW+1)'(push.n) - (QCW+1)'(pop);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop)
				rd_q <= inc(rd_q);
			if (push.n == 2'd1)
				wr_q <= wr1;
			else if (push.n == 2'd2)
				wr_q <= inc(wr1);
			cnt_q <= cnt_n[QCW-1:0];
		end
	end

	// word storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wr1] <= push.r1;
	end

	assign head  = mem_q[rd_q];
	assign count = cnt_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
	import sexpr_tok_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	logic [7:0] ch = 8'h00;
	logic       tok_valid;
	logic       tok_stall = 1'b0;
	logic [7:0] out_char;
	logic [1:0] token_kind;
	logic       token_first;
	logic       token_last;
	logic       unterminated;
	logic       run_last;

	sexpr_tokenizer_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.ch          (ch),
		.tok_valid   (tok_valid),
		.tok_stall   (tok_stall),
		.out_char    (out_char),
		.token_kind  (token_kind),
		.token_first (token_first),
		.token_last  (token_last),
		.unterminated(unterminated),
		.run_last    (run_last)
	);

	// text bytes waiting to be sent, token words waiting to arrive
	logic [7:0] text_bytes[$];
	tok_res_t   tokens_due[$];
	int         n_text = 0;
	int         n_taken = 0;
	int         n_errors = 0;
	logic       quiet;

	// no idling on either side for a stretch in the middle of the run
	assign quiet = n_taken >= 200 && n_taken < 320;

	// lexer shadow state
	lex_mode_t  lx_mode = M_IDLE;
	logic       lx_esc = 1'b0;
	logic       hb_vld = 1'b0;
	logic [7:0] hb_chr = 8'h00;
	logic [1:0] hb_kind = KIND_OPEN;
	logic       hb_first = 1'b0;

	// clock and reset
	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic check(string what, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report($sformatf("%s got %0h, want %0h", what, got, want));
	endtask

	function automatic logic white(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	// ---------------- token predictor ----------------

	function void emit(logic [7:0] c, logic [1:0] k, logic f, logic l, logic u);
		tok_res_t r;
		r.chr      = c;
		r.kind     = k;
		r.first    = f;
		r.last     = l;
		r.unterm   = u;
		r.run_last = 1'b0;
		tokens_due.insert(tokens_due.size(), r);
	endfunction

	function void flush_held(logic l, logic u);
		if (hb_vld)
			emit(hb_chr, hb_kind, hb_first, l, u);
		hb_vld = 1'b0;
	endfunction

	function void hold_byte(logic [7:0] c, logic [1:0] k, logic f);
		hb_vld   = 1'b1;
		hb_chr   = c;
		hb_kind  = k;
		hb_first = f;
	endfunction

	function void lex_clear();
		lx_mode  = M_IDLE;
		lx_esc   = 1'b0;
		hb_vld   = 1'b0;
		hb_chr   = 8'h00;
		hb_kind  = KIND_OPEN;
		hb_first = 1'b0;
	endfunction

	// one text byte in, its token words appended to tokens_due
	function void lex_byte(logic [7:0] c);
		int         n0;
		logic       paren;
		logic [1:0] pk;
		n0 = tokens_due.size();
		paren = c == CH_LPAREN || c == CH_RPAREN;
		pk = (c == CH_LPAREN) ? KIND_OPEN : KIND_CLOSE;
		if (c == CH_NUL) begin
			// end of text: flush, flag a cut-off string, start over
			flush_held(1'b1, lx_mode == M_STRING);
			lex_clear();
		end else begin
			case (lx_mode)
				M_COMMENT: begin
					if (c == CH_LF || c == CH_CR)
						lx_mode = M_IDLE;
				end
				M_SEMI, M_SYMBOL: begin
					if (lx_mode == M_SEMI && c == CH_SEMI) begin
						// double semicolon: drop the held one, comment follows
						hb_vld = 1'b0;
						lx_mode = M_COMMENT;
					end else if (white(c)) begin
						flush_held(1'b1, 1'b0);
						lx_mode = M_IDLE;
					end else if (paren) begin
						flush_held(1'b1, 1'b0);
						emit(c, pk, 1'b1, 1'b1, 1'b0);
						lx_mode = M_IDLE;
					end else begin
						flush_held(1'b0, 1'b0);
						hold_byte(c, KIND_SYMBOL, 1'b0);
						lx_mode = M_SYMBOL;
					end
				end
				M_STRING: begin
					flush_held(1'b0, 1'b0);
					if (lx_esc) begin
						lx_esc = 1'b0;
						hold_byte(c, KIND_STRING, 1'b0);
					end else if (c == CH_BSLASH) begin
						lx_esc = 1'b1;
						hold_byte(c, KIND_STRING, 1'b0);
					end else if (c == CH_QUOTE) begin
						emit(c, KIND_STRING, 1'b0, 1'b1, 1'b0);
						lx_mode = M_IDLE;
					end else begin
						hold_byte(c, KIND_STRING, 1'b0);
					end
				end
				default: begin
					// between tokens
					flush_held(1'b1, 1'b0);
					lx_esc = 1'b0;
					lx_mode = M_IDLE;
					if (white(c)) begin
					end else if (paren) begin
						emit(c, pk, 1'b1, 1'b1, 1'b0);
					end else if (c == CH_QUOTE) begin
						hold_byte(c, KIND_STRING, 1'b1);
						lx_mode = M_STRING;
					end else if (c == CH_SEMI) begin
						hold_byte(c, KIND_SYMBOL, 1'b1);
						lx_mode = M_SEMI;
					end else begin
						hold_byte(c, KIND_SYMBOL, 1'b1);
						lx_mode = M_SYMBOL;
					end
				end
			endcase
		end
		if (tokens_due.size() > n0)
			tokens_due[tokens_due.size() - 1].run_last = 1'b1;
	endfunction

	// ---------------- text generation ----------------

	function automatic void add_byte(logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endfunction

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// symbol byte; a leading one is neither quote nor semicolon
	function automatic logic [7:0] sym_byte(logic lead);
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (white(c) || c == CH_LPAREN || c == CH_RPAREN ||
			(lead && (c == CH_QUOTE || c == CH_SEMI)));
		return c;
	endfunction

	function automatic logic [7:0] blank_byte();
		logic [7:0] set[6];
		set = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		return set[$urandom_range(0, 5)];
	endfunction

	task automatic add_string();
		logic [7:0] c;
		add_byte(CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(99) < 20) begin
				add_byte(CH_BSLASH);
				add_byte(8'($urandom_range(1, 255)));
			end else begin
				do
					c = 8'($urandom_range(1, 255));
				while (c == CH_QUOTE || c == CH_BSLASH);
				add_byte(c);
			end
		end
		// mostly closed, sometimes cut off by end of text
		add_byte($urandom_range(99) < 90 ? CH_QUOTE : CH_NUL);
	endtask

	task automatic add_comment();
		logic [7:0] c;
		add_byte(CH_SEMI);
		add_byte(CH_SEMI);
		repeat ($urandom_range(0, 8)) begin
			do
				c = 8'($urandom_range(1, 255));
			while (c == CH_LF || c == CH_CR);
			add_byte(c);
		end
		add_byte($urandom_range(1) ? CH_LF : CH_CR);
	endtask

	initial begin
		int pick;
		// directed text
		add_text("(a;\"b)");
		add_text(" ;;c\n");
		add_text(";x ");
		add_text("\"\\\"\\\\\"q");
		add_byte(CH_NUL);
		add_byte(CH_SEMI);
		add_byte(CH_NUL);
		add_byte(CH_QUOTE);
		add_byte(8'hFF);
		add_byte(CH_NUL);
		add_text("z\t\v\f\r");
		add_byte(CH_NUL);

		// random text, mostly well-formed tokens
		while (text_bytes.size() < 530) begin
			pick = $urandom_range(99);
			if (pick < 14) begin
				add_byte($urandom_range(1) ? CH_LPAREN : CH_RPAREN);
			end else if (pick < 34) begin
				add_byte(sym_byte(1'b1));
				repeat ($urandom_range(0, 5))
					add_byte(sym_byte(1'b0));
				if ($urandom_range(99) < 80)
					add_byte(blank_byte());
			end else if (pick < 52) begin
				add_string();
			end else if (pick < 62) begin
				add_comment();
			end else if (pick < 72) begin
				repeat ($urandom_range(1, 3))
					add_byte(blank_byte());
			end else if (pick < 78) begin
				add_byte(CH_SEMI);
				repeat ($urandom_range(0, 3))
					add_byte(sym_byte(1'b1));
			end else if (pick < 83) begin
				add_byte(CH_NUL);
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
		add_byte(CH_NUL);
		n_text = text_bytes.size();

		// wait for all text taken, then for the token words to drain
		wait (arst_n && n_taken == n_text);
		for (int i = 0; i < 2000 && tokens_due.size() > 0; i++)
			@(posedge clk);
		if (tokens_due.size() > 0)
			report($sformatf("%0d token words never arrived", tokens_due.size()));
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#200000;
		$display("FAILURE");
		$finish;
	end

	// ---------------- source driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			ch <= CH_NUL;
		end else begin
			if (src_valid && !src_stall) begin
				lex_byte(ch);
				n_taken++;
			end
			// a stalled word holds; otherwise load the next or idle
			if (!src_valid || !src_stall) begin
				if (text_bytes.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
					src_valid <= 1'b1;
					ch <= text_bytes[0];
					text_bytes.delete(0);
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- token sink and checker ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_stall <= 1'b0;
		else
			tok_stall <= !quiet && $urandom_range(99) < 28;
	end

	always @(posedge clk) begin : watch_tokens
		tok_res_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (tokens_due.size() == 0) begin
				report($sformatf("token word %0h with none expected", out_char));
			end else begin
				want = tokens_due[0];
				tokens_due.delete(0);
				check("out_char", out_char, want.chr);
				check("token_kind", 8'(token_kind), 8'(want.kind));
				check("token_first", 8'(token_first), 8'(want.first));
				check("token_last", 8'(token_last), 8'(want.last));
				check("unterminated", 8'(unterminated), 8'(want.unterm));
				check("run_last", 8'(run_last), 8'(want.run_last));
			end
		end
	end

endmodule
